// ===== rtl/frqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frqs_pkg
// Shared types and codes for the fiber run-queue scheduler.
// ----------------------------------------------------------------------------
package frqs_pkg;

  // Command codes carried by the input word
  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_YIELD  = 3'd1,
    CMD_WAIT   = 3'd2,
    CMD_NOTIFY = 3'd3,
    CMD_EXIT   = 3'd4
  } cmd_t;

  // Per-fiber status codes
  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_IDLE     = 3'd1,
    ST_RUNNABLE = 3'd2,
    ST_NOTIFIED = 3'd3,
    ST_WAITING  = 3'd4,
    ST_FINISHED = 3'd5
  } status_t;

  // Width of the fiber id field on the ports
  localparam int ID_W = 4;

  // Largest number of fibers the id field can address
  localparam int ID_SPACE = 1 << ID_W;

endpackage

// ===== rtl/fiber_run_queue_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fiber_run_queue_scheduler
// Cooperative round-robin fiber scheduler with a FIFO run queue.
// Path: an accepted word goes to the input register, then its result to the
//   result register; a stalled result holds the next word in place.
// Throughput: 1 word per cycle unless the result side stalls, set by the
//   single-pass status table and queue pointer update between the registers.
// Reset (rst, synchronous): fiber 0 idle, all others unused, queue empty,
//   idle fiber running; no clearing pass, the block is ready at once.
// ----------------------------------------------------------------------------
module fiber_run_queue_scheduler #(
  parameter int MAX_FIBERS = 16
) (
  input  logic       clk,
  input  logic       rst,
  // command channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] command,
  input  logic [3:0] fiber_id,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] current_fiber,
  output logic [3:0] previous_fiber,
  output logic       switched,
  output logic       rejected,
  output logic [2:0] target_status,
  output logic [3:0] queue_length
);

  // Only ids below the port's id space can ever be touched, so the tables
  // are sized by the smaller of the two.
  localparam int NS = (MAX_FIBERS < frqs_pkg::ID_SPACE) ? MAX_FIBERS : frqs_pkg::ID_SPACE;
  localparam int IW = $clog2(NS);

  // Tables and queue state
  frqs_pkg::status_t status [NS];
  logic [IW-1:0]     run_queue [NS];
  logic [IW-1:0]     queue_head;
  logic [IW-1:0]     queue_tail;
  logic [IW-1:0]     queue_count;
  logic [IW-1:0]     running;

  // Input register
  logic       in_full;
  logic [2:0] cmd_r;
  logic [3:0] id_r;

  // Result register
  logic       res_full;
  logic [3:0] cur_r;
  logic [3:0] prev_r;
  logic       sw_r;
  logic       rej_r;
  logic [2:0] tstat_r;
  logic [3:0] qlen_r;

  logic advance;

  assign advance  = in_full && (!res_full || out_ready);
  assign in_ready = !in_full || advance;

  // Combinational update
  logic              in_range;
  logic [IW-1:0]     tid;
  frqs_pkg::status_t cur_st;
  frqs_pkg::status_t tgt_st;
  logic              st_we;
  logic [IW-1:0]     st_idx;
  frqs_pkg::status_t st_val;
  logic              push;
  logic [IW-1:0]     push_id;
  logic              pop;
  logic              resched;
  logic              requeue;
  logic              rej;
  logic [IW-1:0]     running_next;
  logic [IW-1:0]     queue_head_next;
  logic [IW-1:0]     queue_tail_next;
  logic [IW-1:0]     queue_count_next;
  logic [2:0]        tstat;

  assign in_range = int'(id_r) < MAX_FIBERS;
  assign tid      = id_r[IW-1:0];
  assign cur_st   = status[running];
  assign tgt_st   = status[tid];

  // Command decode: at most one status write and at most one append per command
  always_comb begin
    st_we   = 1'b0;
    st_idx  = tid;
    st_val  = frqs_pkg::ST_RUNNABLE;
    push    = 1'b0;
    push_id = tid;
    resched = 1'b0;
    requeue = 1'b0;
    rej     = 1'b0;
    unique case (cmd_r)
      frqs_pkg::CMD_CREATE: begin
        if (!in_range || tid == '0 || tid == running ||
            (tgt_st != frqs_pkg::ST_UNUSED && tgt_st != frqs_pkg::ST_FINISHED)) begin
          rej = 1'b1;
        end else begin
          st_we = 1'b1;
          push  = 1'b1;
        end
      end
      frqs_pkg::CMD_YIELD: begin
        resched = 1'b1;
        requeue = (cur_st == frqs_pkg::ST_RUNNABLE) || (cur_st == frqs_pkg::ST_NOTIFIED);
      end
      frqs_pkg::CMD_WAIT: begin
        st_idx = running;
        if (cur_st == frqs_pkg::ST_RUNNABLE) begin
          st_we   = 1'b1;
          st_val  = frqs_pkg::ST_WAITING;
          resched = 1'b1;
        end else if (cur_st == frqs_pkg::ST_NOTIFIED) begin
          st_we = 1'b1;
        end
      end
      frqs_pkg::CMD_NOTIFY: begin
        if (in_range) begin
          if (tgt_st == frqs_pkg::ST_RUNNABLE) begin
            st_we  = 1'b1;
            st_val = frqs_pkg::ST_NOTIFIED;
          end else if (tgt_st == frqs_pkg::ST_WAITING) begin
            st_we = 1'b1;
            push  = 1'b1;
          end
        end
      end
      frqs_pkg::CMD_EXIT: begin
        if (running != '0) begin
          st_we   = 1'b1;
          st_idx  = running;
          st_val  = frqs_pkg::ST_FINISHED;
          resched = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Requeue the running fiber only if someone else is waiting; with an
    // empty queue it would just pop itself back.
    if (resched && requeue && queue_count != '0) begin
      push    = 1'b1;
      push_id = running;
    end
    pop = resched && (queue_count != '0);

    running_next = running;
    if (resched) begin
      if (queue_count != '0) begin
        running_next = run_queue[queue_head];
      end else if (!requeue) begin
        running_next = '0;
      end
    end

    queue_head_next = queue_head;
    if (pop) begin
      queue_head_next = (queue_head == IW'(NS - 1)) ? '0 : queue_head + 1'b1;
    end
    queue_tail_next = queue_tail;
    if (push) begin
      queue_tail_next = (queue_tail == IW'(NS - 1)) ? '0 : queue_tail + 1'b1;
    end
    queue_count_next = queue_count + IW'(push) - IW'(pop);

    // Target status after the write
    if (!in_range) begin
      tstat = frqs_pkg::ST_UNUSED;
    end else if (st_we && st_idx == tid) begin
      tstat = st_val;
    end else begin
      tstat = tgt_st;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_ready && in_valid) begin
      cmd_r <= command;
      id_r  <= fiber_id;
    end
  end

  // Scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        status[i] <= (i == 0) ? frqs_pkg::ST_IDLE : frqs_pkg::ST_UNUSED;
      end
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
      running     <= '0;
    end else if (advance) begin
      if (st_we) begin
        status[st_idx] <= st_val;
      end
      queue_head  <= queue_head_next;
      queue_tail  <= queue_tail_next;
      queue_count <= queue_count_next;
      running     <= running_next;
    end
  end

  // Run queue ring
  always_ff @(posedge clk) begin
    if (advance && push) begin
      run_queue[queue_tail] <= push_id;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= 1'b1;
    end else if (out_ready) begin
      res_full <= 1'b0;
    end
    if (advance) begin
      cur_r   <= 4'(running_next);
      prev_r  <= 4'(running);
      sw_r    <= running_next != running;
      rej_r   <= rej;
      tstat_r <= tstat;
      qlen_r  <= 4'(queue_count_next);
    end
  end

  assign out_valid      = res_full;
  assign current_fiber  = cur_r;
  assign previous_fiber = prev_r;
  assign switched       = sw_r;
  assign rejected       = rej_r;
  assign target_status  = tstat_r;
  assign queue_length   = qlen_r;

endmodule

// ===== test/tb_fiber_run_queue_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fiber_run_queue_scheduler
// Self-checking bench for the fiber run-queue scheduler. A short table of
// commands covers the corner cases (refused creates, no-op waits, exits and
// notifies, unknown codes), then about 1300 random commands follow, mostly
// legal scheduling traffic with some noise. Each accepted command word runs
// through a scheduler model in the bench. Each result word is compared field
// by field with the oldest predicted result. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_fiber_run_queue_scheduler;

  localparam int NUM_FIBERS   = frqs_pkg::ID_SPACE;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CALM_FIRST   = 400;
  localparam int CALM_LAST    = 600;
  localparam int DRAIN_AT     = 800;
  localparam int TAIL_CYCLES  = 8;
  localparam int RUN_LIMIT_NS = 2_000_000;

  // command codes outside the defined set
  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [3:0] cur;
    logic [3:0] prev;
    logic       sw;
    logic       rej;
    logic [2:0] ts;
    logic [3:0] qlen;
  } outcome_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] id;
    logic       typed;
    outcome_t   want;
  } stim_row_t;

  localparam outcome_t NO_CHECK = '0;

  // directed table; typed rows carry their own expected word
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{frqs_pkg::CMD_YIELD, 4'd0, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0, frqs_pkg::ST_IDLE, 4'd0}},
    '{frqs_pkg::CMD_WAIT, 4'd15, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0, frqs_pkg::ST_UNUSED, 4'd0}},
    '{frqs_pkg::CMD_EXIT, 4'd0, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0, frqs_pkg::ST_IDLE, 4'd0}},
    '{frqs_pkg::CMD_NOTIFY, 4'd5, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0, frqs_pkg::ST_UNUSED, 4'd0}},
    '{frqs_pkg::CMD_CREATE, 4'd0, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b1, frqs_pkg::ST_IDLE, 4'd0}},
    '{CMD_UNKNOWN_LO, 4'd3, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0, frqs_pkg::ST_UNUSED, 4'd0}},
    '{CMD_UNKNOWN_HI, 4'd15, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0, frqs_pkg::ST_UNUSED, 4'd0}},
    '{frqs_pkg::CMD_CREATE, 4'd15, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0, frqs_pkg::ST_RUNNABLE, 4'd1}},
    '{frqs_pkg::CMD_CREATE, 4'd15, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b1, frqs_pkg::ST_RUNNABLE, 4'd1}},
    '{frqs_pkg::CMD_CREATE, 4'd1,  1'b0, NO_CHECK},
    '{frqs_pkg::CMD_NOTIFY, 4'd0,  1'b0, NO_CHECK},
    '{frqs_pkg::CMD_YIELD,  4'd0,  1'b0, NO_CHECK},
    '{frqs_pkg::CMD_CREATE, 4'd15, 1'b0, NO_CHECK},
    '{frqs_pkg::CMD_NOTIFY, 4'd15, 1'b0, NO_CHECK},
    '{frqs_pkg::CMD_NOTIFY, 4'd15, 1'b0, NO_CHECK},
    '{frqs_pkg::CMD_WAIT,   4'd0,  1'b0, NO_CHECK},
    '{frqs_pkg::CMD_WAIT,   4'd0,  1'b0, NO_CHECK},
    '{frqs_pkg::CMD_NOTIFY, 4'd15, 1'b0, NO_CHECK},
    '{frqs_pkg::CMD_EXIT,   4'd0,  1'b0, NO_CHECK},
    '{frqs_pkg::CMD_CREATE, 4'd1,  1'b0, NO_CHECK},
    '{frqs_pkg::CMD_YIELD,  4'd0,  1'b0, NO_CHECK},
    '{frqs_pkg::CMD_EXIT,   4'd0,  1'b0, NO_CHECK},
    '{frqs_pkg::CMD_EXIT,   4'd0,  1'b0, NO_CHECK},
    '{frqs_pkg::CMD_CREATE, 4'd15, 1'b0, NO_CHECK},
    '{frqs_pkg::CMD_YIELD,  4'd1,  1'b0, NO_CHECK}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] command = '0;
  logic [3:0] fiber_id = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] current_fiber;
  logic [3:0] previous_fiber;
  logic       switched;
  logic       rejected;
  logic [2:0] target_status;
  logic [3:0] queue_length;

  // no random stalls on either side while set
  logic       calm = 1'b0;
  int         error_count = 0;
  outcome_t   pending_outcomes [$];
  outcome_t   oldest;

  // scheduler model state
  frqs_pkg::status_t fiber_state [NUM_FIBERS];
  logic [3:0]        ring [NUM_FIBERS];
  int                ring_head;
  int                ring_tail;
  int                ring_count;
  logic [3:0]        running;

  fiber_run_queue_scheduler u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .fiber_id       (fiber_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .current_fiber  (current_fiber),
    .previous_fiber (previous_fiber),
    .switched       (switched),
    .rejected       (rejected),
    .target_status  (target_status),
    .queue_length   (queue_length)
  );

  always #2 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // append to the run queue; a full queue drops the fiber
  function automatic void enqueue_fiber(input logic [3:0] f);
    if (ring_count >= NUM_FIBERS) return;
    ring[ring_tail] = f;
    ring_tail = (ring_tail + 1) % NUM_FIBERS;
    ring_count++;
  endfunction

  // requeue a live running fiber, then run the head or fall back to idle
  function automatic void switch_next();
    if (fiber_state[running] == frqs_pkg::ST_RUNNABLE ||
        fiber_state[running] == frqs_pkg::ST_NOTIFIED)
      enqueue_fiber(running);
    if (ring_count == 0) begin
      running = '0;
    end else begin
      running = ring[ring_head];
      ring_head = (ring_head + 1) % NUM_FIBERS;
      ring_count--;
    end
  endfunction

  // advance the model by one command word and return its result word
  function automatic outcome_t schedule_step(input logic [2:0] cmd, input logic [3:0] id);
    outcome_t   r;
    logic [3:0] prev;
    logic       in_range;
    logic       refused;
    in_range = int'(id) < NUM_FIBERS;
    prev     = running;
    refused  = 1'b0;
    case (cmd)
      frqs_pkg::CMD_CREATE: begin
        if (!in_range || id == 4'd0 || id == running ||
            (fiber_state[id] != frqs_pkg::ST_UNUSED &&
             fiber_state[id] != frqs_pkg::ST_FINISHED)) begin
          refused = 1'b1;
        end else begin
          fiber_state[id] = frqs_pkg::ST_RUNNABLE;
          enqueue_fiber(id);
        end
      end
      frqs_pkg::CMD_YIELD: switch_next();
      frqs_pkg::CMD_WAIT: begin
        if (fiber_state[running] == frqs_pkg::ST_RUNNABLE) begin
          fiber_state[running] = frqs_pkg::ST_WAITING;
          switch_next();
        end else if (fiber_state[running] == frqs_pkg::ST_NOTIFIED) begin
          fiber_state[running] = frqs_pkg::ST_RUNNABLE;
        end
      end
      frqs_pkg::CMD_NOTIFY: begin
        if (in_range) begin
          if (fiber_state[id] == frqs_pkg::ST_RUNNABLE) begin
            fiber_state[id] = frqs_pkg::ST_NOTIFIED;
          end else if (fiber_state[id] == frqs_pkg::ST_WAITING) begin
            fiber_state[id] = frqs_pkg::ST_RUNNABLE;
            enqueue_fiber(id);
          end
        end
      end
      frqs_pkg::CMD_EXIT: begin
        if (running != 4'd0) begin
          fiber_state[running] = frqs_pkg::ST_FINISHED;
          switch_next();
        end
      end
      default: ;
    endcase
    r.cur  = running;
    r.prev = prev;
    r.sw   = running != prev;
    r.rej  = refused;
    r.ts   = in_range ? fiber_state[id] : frqs_pkg::ST_UNUSED;
    r.qlen = 4'(ring_count);
    return r;
  endfunction

  // mostly scheduling traffic, a little noise from undefined codes
  function automatic logic [2:0] pick_command();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 28) return frqs_pkg::CMD_CREATE;
    if (roll < 52) return frqs_pkg::CMD_YIELD;
    if (roll < 66) return frqs_pkg::CMD_WAIT;
    if (roll < 86) return frqs_pkg::CMD_NOTIFY;
    if (roll < 97) return frqs_pkg::CMD_EXIT;
    return CMD_UNKNOWN_LO + 3'($urandom_range(CMD_UNKNOWN_HI - CMD_UNKNOWN_LO));
  endfunction

  // random idle cycles ahead of the next word
  task automatic pace_gap();
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // present one word, hold it until taken, then log its expected result
  task automatic drive_word(input logic [2:0] cmd, input logic [3:0] id,
                            input logic typed, input outcome_t want);
    outcome_t predicted;
    in_valid <= 1'b1;
    command  <= cmd;
    fiber_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = schedule_step(cmd, id);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  // result side: random back-pressure and compare against oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          flag_error("result word with nothing pending");
        end else begin
          oldest = pending_outcomes.pop_front();
          if (current_fiber != oldest.cur)
            flag_error($sformatf("current_fiber %0d, want %0d", current_fiber, oldest.cur));
          if (previous_fiber != oldest.prev)
            flag_error($sformatf("previous_fiber %0d, want %0d", previous_fiber, oldest.prev));
          if (switched != oldest.sw)
            flag_error($sformatf("switched %0b, want %0b", switched, oldest.sw));
          if (rejected != oldest.rej)
            flag_error($sformatf("rejected %0b, want %0b", rejected, oldest.rej));
          if (target_status != oldest.ts)
            flag_error($sformatf("target_status %0d, want %0d", target_status, oldest.ts));
          if (queue_length != oldest.qlen)
            flag_error($sformatf("queue_length %0d, want %0d", queue_length, oldest.qlen));
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  // stimulus and end of run
  initial begin
    for (int f = 0; f < NUM_FIBERS; f++) begin
      fiber_state[f] = frqs_pkg::ST_UNUSED;
      ring[f] = '0;
    end
    fiber_state[0] = frqs_pkg::ST_IDLE;
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
    running    = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      pace_gap();
      drive_word(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].id,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= CALM_FIRST && n < CALM_LAST);
      // let the block drain completely once
      if (n == DRAIN_AT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_outcomes.size() != 0);
      end
      pace_gap();
      drive_word(pick_command(), 4'($urandom_range(NUM_FIBERS - 1)), 1'b0, NO_CHECK);
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
